// ===== design/tls_pkg.sv =====
package tls_pkg;

  localparam int unsigned TICK_W = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TICK_W-1:0] tick_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_EW_GREEN  = 3'd0,
    PH_EW_YELLOW = 3'd1,
    PH_RED_A     = 3'd2,
    PH_NS_GREEN  = 3'd3,
    PH_NS_YELLOW = 3'd4,
    PH_RED_B     = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YELLOW    = 3'd0,
    CFG_ALL_RED   = 3'd1,
    CFG_NORMAL    = 3'd2,
    CFG_EXTENDED  = 3'd3,
    CFG_EMERGENCY = 3'd4
  } cfg_idx_t;

  localparam tick_t YELLOW_RST    = 8'd2;
  localparam tick_t ALL_RED_RST   = 8'd1;
  localparam tick_t NORMAL_RST    = 8'd5;
  localparam tick_t EXTENDED_RST  = 8'd7;
  localparam tick_t EMERGENCY_RST = 8'd3;

  typedef struct packed {
    logic ns_red;
    logic ns_yellow;
    logic ns_green;
    logic ew_red;
    logic ew_yellow;
    logic ew_green;
  } lamps_t;

  localparam lamps_t LAMPS_ALL_RED = '{ns_red: 1'b1, ns_yellow: 1'b0, ns_green: 1'b0,
                                       ew_red: 1'b1, ew_yellow: 1'b0, ew_green: 1'b0};

  function automatic tick_t at_least_one(input tick_t v);
    return (v == '0) ? tick_t'(1) : v;
  endfunction

  function automatic phase_t next_phase(input phase_t p);
    phase_t n;
    case (p)
      PH_EW_GREEN:  n = PH_EW_YELLOW;
      PH_EW_YELLOW: n = PH_RED_A;
      PH_RED_A:     n = PH_NS_GREEN;
      PH_NS_GREEN:  n = PH_NS_YELLOW;
      PH_NS_YELLOW: n = PH_RED_B;
      default:      n = PH_EW_GREEN;
    endcase
    return n;
  endfunction

  function automatic lamps_t phase_lamps(input phase_t p);
    lamps_t l;
    l = LAMPS_ALL_RED;
    case (p)
      PH_EW_GREEN: begin
        l.ew_red   = 1'b0;
        l.ew_green = 1'b1;
      end
      PH_EW_YELLOW: begin
        l.ew_red    = 1'b0;
        l.ew_yellow = 1'b1;
        l.ew_green  = 1'b1;
      end
      PH_NS_GREEN: begin
        l.ns_red   = 1'b0;
        l.ns_green = 1'b1;
      end
      PH_NS_YELLOW: begin
        l.ns_red    = 1'b0;
        l.ns_yellow = 1'b1;
        l.ns_green  = 1'b1;
      end
      default: l = LAMPS_ALL_RED;
    endcase
    return l;
  endfunction

endpackage

// ===== design/traffic_light_sequencer.sv =====
// Two-road traffic light sequencer, one input beat per one-second tick.
// Input channel (in_valid / in_stall): sensor bits of both roads and an
// emergency event flag. Each accepted beat yields exactly one result beat.
// Result channel (out_valid / out_stall): six lamp bits, the current phase
// and the emergency flag, in the phase state after that tick.
// Configuration (cfg_we / cfg_index / cfg_wdata): five 8-bit duration
// registers, written by the user only while the block is idle, which the block
// does not enforce; unknown indexes are ignored. Each result is registered.
// Throughput: one beat per cycle; the phase and timer update for a tick is
// a single registered step from the state registers to the result register.
// A new beat is taken while the result register is empty or being drained,
// so in_stall follows out_stall only when a result is held.
// Reset: phase is the last all-red phase with one tick left, so a first beat
// without emergency enters EW green; no emergency hold runs; durations default.
// Receiver stall: the result register holds its beat and the input stalls.
module traffic_light_sequencer
  import tls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_ew_sensors,
  input  logic [1:0]           in_ns_sensors,
  input  logic                 in_emergency_event,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_ns_red,
  output logic                 out_ns_yellow,
  output logic                 out_ns_green,
  output logic                 out_ew_red,
  output logic                 out_ew_yellow,
  output logic                 out_ew_green,
  output logic [PHASE_W-1:0]   out_current_phase,
  output logic                 out_emergency_active,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  tick_t  yellow_r, all_red_r, normal_r, extended_r, emergency_r;
  phase_t phase_r, phase_nxt;
  tick_t  phase_left_r, phase_left_nxt;
  tick_t  emerg_left_r, emerg_left_nxt;
  logic   emerg_nxt;
  tick_t  emerg_cur;
  tick_t  green_len;
  logic   sensed;

  logic   out_valid_r;
  lamps_t out_lamps_r;
  phase_t out_phase_r;
  logic   out_emerg_r;

  logic   in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yellow_r    <= YELLOW_RST;
      all_red_r   <= ALL_RED_RST;
      normal_r    <= NORMAL_RST;
      extended_r  <= EXTENDED_RST;
      emergency_r <= EMERGENCY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_YELLOW:    yellow_r    <= cfg_wdata;
        CFG_ALL_RED:   all_red_r   <= cfg_wdata;
        CFG_NORMAL:    normal_r    <= cfg_wdata;
        CFG_EXTENDED:  extended_r  <= cfg_wdata;
        CFG_EMERGENCY: emergency_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    emerg_cur      = in_emergency_event ? at_least_one(emergency_r) : emerg_left_r;
    phase_nxt      = phase_r;
    phase_left_nxt = phase_left_r;
    emerg_left_nxt = emerg_left_r;
    emerg_nxt      = 1'b0;
    sensed         = 1'b0;
    green_len      = '0;
    if (emerg_cur != '0) begin
      emerg_left_nxt = emerg_cur - tick_t'(1);
      emerg_nxt      = 1'b1;
    end else if (phase_left_r > tick_t'(1)) begin
      phase_left_nxt = phase_left_r - tick_t'(1);
    end else begin
      phase_nxt = next_phase(phase_r);
      sensed    = (phase_nxt == PH_EW_GREEN) ? (in_ew_sensors != '0)
                                             : (in_ns_sensors != '0);
      green_len = at_least_one(sensed ? extended_r : normal_r);
      case (phase_nxt)
        PH_EW_GREEN, PH_NS_GREEN:   phase_left_nxt = green_len;
        PH_EW_YELLOW, PH_NS_YELLOW: phase_left_nxt = at_least_one(yellow_r);
        default:                    phase_left_nxt = at_least_one(all_red_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RED_B;
      phase_left_r <= tick_t'(1);
      emerg_left_r <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      phase_left_r <= phase_left_nxt;
      emerg_left_r <= emerg_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_lamps_r <= emerg_nxt ? LAMPS_ALL_RED : phase_lamps(phase_nxt);
      out_phase_r <= phase_nxt;
      out_emerg_r <= emerg_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ns_red           = out_lamps_r.ns_red;
  assign out_ns_yellow        = out_lamps_r.ns_yellow;
  assign out_ns_green         = out_lamps_r.ns_green;
  assign out_ew_red           = out_lamps_r.ew_red;
  assign out_ew_yellow        = out_lamps_r.ew_yellow;
  assign out_ew_green         = out_lamps_r.ew_green;
  assign out_current_phase    = out_phase_r;
  assign out_emergency_active = out_emerg_r;

  a_event_shows_emergency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_emergency_event) |=> (out_valid && out_emergency_active))
    else $error("emergency beat did not produce an emergency result");

  a_emergency_all_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_emergency_active) |->
      (out_ns_red && out_ew_red && !out_ns_green && !out_ew_green &&
       !out_ns_yellow && !out_ew_yellow))
    else $error("lamps not all red during emergency hold");

  a_hold_freezes_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emerg_left_r != '0) |=> $stable(phase_r))
    else $error("phase moved during emergency hold");

  a_green_never_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_ns_green && out_ew_green))
    else $error("both roads green");

endmodule
